// ----- src/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants, codes and types for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

	localparam int MAX_VOICES_DEF = 16;
	localparam int AGE_WIDTH_DEF  = 32;

	localparam int FUNC_W = 2;
	localparam int NOTE_W = 7;
	localparam int MASK_W = 16;
	localparam int SLOT_W = 4;
	localparam int ACT_W  = 2;
	localparam int TIER_W = 2;

	localparam logic [FUNC_W-1:0] FUNC_NOTE_ON   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALL_NOTES = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_ALL_SOUND = 2'd3;

	localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_KILL    = 2'd2;

	localparam logic [TIER_W-1:0] TIER_IDLE     = 2'd0;
	localparam logic [TIER_W-1:0] TIER_RELEASED = 2'd1;
	localparam logic [TIER_W-1:0] TIER_STOLEN   = 2'd2;

	// Status of the running slot search
	typedef struct packed {
		logic free_found;
		logic rel_found;
	} scan_flags_t;

endpackage

`default_nettype wire

// ----- src/pva_slot_store.sv -----
// ----------------------------------------------------------------------------
// pva_slot_store
// Per-slot note and age memory with one write port, one registered read port
// and a valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pva_slot_store
	import pva_pkg::*;
#(
	parameter int NV = MAX_VOICES_DEF,
	parameter int AW = AGE_WIDTH_DEF,
	parameter int IW = $clog2(NV)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [IW-1:0]     waddr,
	input  wire logic [NOTE_W-1:0] wnote,
	input  wire logic [AW-1:0]     wage,
	input  wire logic              re,
	input  wire logic [IW-1:0]     raddr,
	output logic      [NOTE_W-1:0] rnote,
	output logic      [AW-1:0]     rage
);

	logic [NOTE_W-1:0] note_mem [NV];
	logic [AW-1:0]     age_mem  [NV];
	logic [NV-1:0]     valid_q;
	logic [NOTE_W-1:0] rnote_q;
	logic [AW-1:0]     rage_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			note_mem[waddr] <= wnote;
			age_mem[waddr]  <= wage;
		end
		if (re) begin
			rnote_q <= note_mem[raddr];
			rage_q  <= age_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= valid_q[raddr];
		end
	end

	// unwritten entry reads as zero
	assign rnote = rvalid_q ? rnote_q : '0;
	assign rage  = rvalid_q ? rage_q : '0;

endmodule

`default_nettype wire

// ----- src/pva_scan_unit.sv -----
// ----------------------------------------------------------------------------
// pva_scan_unit
// Running search over one slot per cycle while en is high: first idle slot, oldest released
// slot and oldest slot overall, using one pair of age comparators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pva_scan_unit
	import pva_pkg::*;
#(
	parameter int AW = AGE_WIDTH_DEF,
	parameter int IW = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clear,
	input  wire logic          en,
	input  wire logic [IW-1:0] idx,
	input  wire logic          held,
	input  wire logic          sounding,
	input  wire logic [AW-1:0] age,
	output scan_flags_t        flags,
	output logic      [IW-1:0] free_idx,
	output logic      [IW-1:0] rel_idx,
	output logic      [IW-1:0] old_idx
);

	logic          free_found_q, rel_found_q, old_found_q;
	logic [IW-1:0] free_idx_q, rel_idx_q, old_idx_q;
	logic [AW-1:0] rel_age_q, old_age_q;
	logic          take_free, take_rel, take_old;

	assign take_free = en && !free_found_q && !held && !sounding;
	// strict compare keeps the lowest slot on equal ages
	assign take_rel  = en && !held && (!rel_found_q || (age < rel_age_q));
	assign take_old  = en && (!old_found_q || (age < old_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			rel_found_q  <= 1'b0;
			old_found_q  <= 1'b0;
		end else if (clear) begin
			free_found_q <= 1'b0;
			rel_found_q  <= 1'b0;
			old_found_q  <= 1'b0;
		end else begin
			if (take_free)
				free_found_q <= 1'b1;
			if (take_rel)
				rel_found_q <= 1'b1;
			if (take_old)
				old_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_free)
			free_idx_q <= idx;
		if (take_rel) begin
			rel_idx_q <= idx;
			rel_age_q <= age;
		end
		if (take_old) begin
			old_idx_q <= idx;
			old_age_q <= age;
		end
	end

	assign flags.free_found = free_found_q;
	assign flags.rel_found  = rel_found_q;
	assign free_idx = free_idx_q;
	assign rel_idx  = rel_idx_q;
	assign old_idx  = old_idx_q;

endmodule

`default_nettype wire

// ----- src/polyphonic_voice_allocator.sv -----
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator
// Voice-slot allocator with oldest-note stealing for a polyphonic synth.
// ----------------------------------------------------------------------------
// One event is taken when start is high and busy is low; busy then stays high
// until the event's results are out. Note-on and note-off read every slot's
// note and age through the single read port of the slot memory, one slot per
// cycle. All-notes-off and all-sound-off give one result per cycle. Each
// result appears for one cycle with result_valid high and cannot be held off
// by the receiver; last marks the final result of an event, and a note-off
// that matches no held slot gives none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_voice_allocator
	import pva_pkg::*;
#(
	parameter int MAX_VOICES = MAX_VOICES_DEF,
	parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [NOTE_W-1:0] note,
	input  wire logic [MASK_W-1:0] sounding_mask,
	output logic                   result_valid,
	output logic      [SLOT_W-1:0] slot,
	output logic      [ACT_W-1:0]  action,
	output logic      [NOTE_W-1:0] voice_note,
	output logic      [TIER_W-1:0] choice_tier,
	output logic                   last
);

	localparam int IW = $clog2(MAX_VOICES);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_VOICES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_BULK
	} state_t;

	state_t            state_q;
	logic [FUNC_W-1:0] func_q;
	logic [NOTE_W-1:0] note_q;
	logic [MASK_W-1:0] mask_q;
	logic [MAX_VOICES-1:0] held_q;
	logic [AGE_WIDTH-1:0]  age_q;
	logic [IW-1:0]     addr_q;
	logic              issue_q;
	logic              pend_q;
	logic [IW-1:0]     pend_idx_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;

	logic              result_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ACT_W-1:0]  action_q;
	logic [NOTE_W-1:0] voice_note_q;
	logic [TIER_W-1:0] choice_tier_q;
	logic              last_q;

	logic              accept;
	logic [NOTE_W-1:0] rd_note;
	logic [AGE_WIDTH-1:0] rd_age;
	logic [31:0]       idx_ext;
	logic              sounding;
	logic              held_s1;
	logic              match_s1;
	scan_flags_t       flags;
	logic [IW-1:0]     free_idx, rel_idx, old_idx;
	logic [IW-1:0]     sel_idx;
	logic [TIER_W-1:0] sel_tier;
	logic              wr_en;
	logic [AGE_WIDTH-1:0] age_next;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign idx_ext  = 32'(idx_s1);
	// slots past the mask width never sound
	assign sounding = (idx_ext < 32'(MASK_W)) && mask_q[idx_ext[3:0]];
	assign held_s1  = held_q[idx_s1];
	assign match_s1 = vld_s1 && (func_q == FUNC_NOTE_OFF) && held_s1 && (rd_note == note_q);
	assign age_next = age_q + AGE_WIDTH'(1);
	assign wr_en    = (state_q == ST_FINISH) && (func_q == FUNC_NOTE_ON);

	always_comb begin
		if (flags.free_found) begin
			sel_idx  = free_idx;
			sel_tier = TIER_IDLE;
		end else if (flags.rel_found) begin
			sel_idx  = rel_idx;
			sel_tier = TIER_RELEASED;
		end else begin
			sel_idx  = old_idx;
			sel_tier = TIER_STOLEN;
		end
	end

	pva_slot_store #(
		.NV(MAX_VOICES),
		.AW(AGE_WIDTH),
		.IW(IW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (wr_en),
		.waddr (sel_idx),
		.wnote (note_q),
		.wage  (age_next),
		.re    (issue_q),
		.raddr (addr_q),
		.rnote (rd_note),
		.rage  (rd_age)
	);

	pva_scan_unit #(
		.AW(AGE_WIDTH),
		.IW(IW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (accept),
		.en      (vld_s1),
		.idx     (idx_s1),
		.held    (held_s1),
		.sounding(sounding),
		.age     (rd_age),
		.flags   (flags),
		.free_idx(free_idx),
		.rel_idx (rel_idx),
		.old_idx (old_idx)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			note_q <= note;
			mask_q <= sounding_mask;
		end
		idx_s1 <= addr_q;
		if (match_s1)
			pend_idx_q <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			held_q         <= '0;
			age_q          <= '0;
			addr_q         <= '0;
			issue_q        <= 1'b0;
			vld_s1         <= 1'b0;
			pend_q         <= 1'b0;
			result_valid_q <= 1'b0;
			slot_q         <= '0;
			action_q       <= ACT_START;
			voice_note_q   <= '0;
			choice_tier_q  <= TIER_IDLE;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= issue_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						pend_q <= 1'b0;
						if ((func == FUNC_NOTE_ON) || (func == FUNC_NOTE_OFF)) begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							held_q  <= '0;
							state_q <= ST_BULK;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						addr_q <= addr_q + IW'(1);
						if (addr_q == LAST_IDX)
							issue_q <= 1'b0;
					end
					// hold each match until the next one shows it was not the last
					if (match_s1) begin
						held_q[idx_s1] <= 1'b0;
						pend_q         <= 1'b1;
						if (pend_q) begin
							result_valid_q <= 1'b1;
							slot_q         <= SLOT_W'(pend_idx_q);
							action_q       <= ACT_RELEASE;
							voice_note_q   <= note_q;
							choice_tier_q  <= TIER_IDLE;
							last_q         <= 1'b0;
						end
					end
					if (vld_s1 && (idx_s1 == LAST_IDX))
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (func_q == FUNC_NOTE_ON) begin
						age_q           <= age_next;
						held_q[sel_idx] <= 1'b1;
						result_valid_q  <= 1'b1;
						slot_q          <= SLOT_W'(sel_idx);
						action_q        <= ACT_START;
						voice_note_q    <= note_q;
						choice_tier_q   <= sel_tier;
						last_q          <= 1'b1;
					end else if (pend_q) begin
						result_valid_q <= 1'b1;
						slot_q         <= SLOT_W'(pend_idx_q);
						action_q       <= ACT_RELEASE;
						voice_note_q   <= note_q;
						choice_tier_q  <= TIER_IDLE;
						last_q         <= 1'b1;
					end
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_BULK: begin
					result_valid_q <= 1'b1;
					slot_q         <= SLOT_W'(addr_q);
					action_q       <= (func_q == FUNC_ALL_NOTES) ? ACT_RELEASE : ACT_KILL;
					voice_note_q   <= note_q;
					choice_tier_q  <= TIER_IDLE;
					last_q         <= (addr_q == LAST_IDX);
					addr_q         <= addr_q + IW'(1);
					if (addr_q == LAST_IDX)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign slot         = slot_q;
	assign action       = action_q;
	assign voice_note   = voice_note_q;
	assign choice_tier  = choice_tier_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- src/pva_checker.sv -----
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the voice allocator's command and result sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pva_checker
	import pva_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire logic [ACT_W-1:0]  action,
	input wire logic [TIER_W-1:0] choice_tier,
	input wire logic              last
);

	// an accepted transaction always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after an accepted transaction");

	// the final result frees the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |-> !busy)
		else $error("busy still high on the last result");

	// a start never has a follower
	a_start_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (action == ACT_START)) |-> last)
		else $error("start result not marked last");

	a_tier_only_start: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (action != ACT_START)) |-> (choice_tier == TIER_IDLE))
		else $error("tier set on a release or kill result");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((action == ACT_START) || (action == ACT_RELEASE) ||
			(action == ACT_KILL)) && (choice_tier != 2'd3))
		else $error("undefined action or tier code");

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.action      (action),
	.choice_tier (choice_tier),
	.last        (last)
);

`default_nettype wire
